// ===== design/sarsa_aqm_agent_macros.svh =====
// assertion macros for the queue-management agent
`ifndef SARSA_AQM_AGENT_MACROS_SVH
`define SARSA_AQM_AGENT_MACROS_SVH

`ifndef SYNTHESIS
`define SARSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SARSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SARSA_ASSERT_NOW(lbl, ante, cons, msg)
`define SARSA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/sarsa_pkg.sv =====
// shared types, codes and constants of the queue-management agent
`timescale 1ns / 1ps

package sarsa_pkg;

  localparam int BW_BUCKETS_DEF    = 16;
  localparam int QUEUE_BUCKETS_DEF = 32;
  localparam int DROP_BUCKETS_DEF  = 8;

  localparam int NUM_ACTIONS  = 3;
  localparam int BW_QUANTUM   = 100;
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DECAY_STEP   = 1000;

  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic       KIND_UPDATE = 1'b0;
  localparam logic       KIND_CHOOSE = 1'b1;

  localparam logic [1:0] ACT_PASS = 2'd0;
  localparam logic [1:0] ACT_ECN  = 2'd1;
  localparam logic [1:0] ACT_DROP = 2'd2;

  localparam int         CFG_IDX_W       = 3;
  localparam logic [2:0] CFG_LEARN_RATE  = 3'd0;
  localparam logic [2:0] CFG_DISCOUNT    = 3'd1;
  localparam logic [2:0] CFG_EXPLORE_DIV = 3'd2;
  localparam logic [2:0] CFG_OBSERVE     = 3'd3;
  localparam logic [2:0] CFG_FROZEN      = 3'd4;
  localparam logic [2:0] CFG_DECAY       = 3'd5;

  localparam logic [15:0] LEARN_RATE_RST = 16'd6554;
  localparam logic [15:0] DISCOUNT_RST   = 16'd58982;

  typedef struct packed {
    logic               kind;
    logic [31:0]        bandwidth;
    logic [15:0]        queue_length;
    logic [15:0]        drop_count;
    logic [1:0]         next_act;
    logic signed [31:0] reward;
    logic [30:0]        random_value;
    logic [31:0]        now;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic       explored;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_RDN,
    S_MUL1,
    S_INNER,
    S_MUL2,
    S_WB,
    S_CRD0,
    S_CRD1,
    S_CRD2,
    S_CFIN,
    S_OUT
  } state_t;

endpackage

// ===== design/sarsa_qmem.sv =====
// q value table, one write port and one registered read port
`timescale 1ns / 1ps

module sarsa_qmem #(
  parameter int DEPTH = 12288,
  parameter int AW    = 14
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic signed [31:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic signed [31:0] rd_data
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/sarsa_mul.sv =====
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module sarsa_mul (
  input  logic                                clk,
  input  logic signed [sarsa_pkg::MUL_A_W-1:0] mul_a,
  input  logic signed [sarsa_pkg::MUL_B_W-1:0] mul_b,
  output logic signed [sarsa_pkg::PROD_W-1:0]  prod
);

  logic signed [sarsa_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= sarsa_pkg::PROD_W'(mul_a) * sarsa_pkg::PROD_W'(mul_b);
  end

  assign prod = prod_r;

endmodule

// ===== design/sarsa_aqm_agent.sv =====
// top level of the tabular sarsa queue-management agent
//
// The agent holds one Q16.16 value for each (bandwidth, queue, drop) bucket and action in a
// table memory with one write and one read port, and the learning and exploration products
// go through one shared multiplier. After reset the table is cleared one entry a cycle, all
// BW_BUCKETS*QUEUE_BUCKETS*DROP_BUCKETS*3 entries (12288 with the default sizes), and no item
// is taken meanwhile; configuration writes are accepted at all times. An update item makes
// two dependent table reads and two dependent multiplies through the shared unit, then the
// write-back; an update while frozen leaves the agent idle. A choose item that passes in the
// observation window or explores goes straight to the output; otherwise it compares the
// three actions read in sequence through the table port. Results sit in an output register,
// so the next item can be accepted while a result waits to be taken.
`timescale 1ns / 1ps

module sarsa_aqm_agent #(
  parameter int BW_BUCKETS    = sarsa_pkg::BW_BUCKETS_DEF,
  parameter int QUEUE_BUCKETS = sarsa_pkg::QUEUE_BUCKETS_DEF,
  parameter int DROP_BUCKETS  = sarsa_pkg::DROP_BUCKETS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sarsa_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sarsa_pkg::out_item_t             out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sarsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data
);

  `include "sarsa_aqm_agent_macros.svh"

  localparam int DEPTH = BW_BUCKETS * QUEUE_BUCKETS * DROP_BUCKETS * sarsa_pkg::NUM_ACTIONS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BWW   = (BW_BUCKETS > 1) ? $clog2(BW_BUCKETS) : 1;
  localparam int QW    = $clog2(QUEUE_BUCKETS);
  localparam int DW    = (DROP_BUCKETS > 1) ? $clog2(DROP_BUCKETS) : 1;

  localparam logic [AW-1:0] QB_A   = AW'(QUEUE_BUCKETS);
  localparam logic [AW-1:0] DB_A   = AW'(DROP_BUCKETS);
  localparam logic [AW-1:0] ACT_A  = AW'(sarsa_pkg::NUM_ACTIONS);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

  localparam logic [31:0] BW_DIV_LIMIT = 32'(sarsa_pkg::BW_QUANTUM * BW_BUCKETS);
  localparam logic [27:0] DIV100_K     = 28'(sarsa_pkg::DIV100_MUL);

  localparam logic signed [sarsa_pkg::PROD_W-1:0] RAND_TOP =
    sarsa_pkg::PROD_W'(64'sd2147483647);
  localparam logic signed [34:0] Q_MAX = 35'sd2147483647;
  localparam logic signed [34:0] Q_MIN = -35'sd2147483648;
  localparam logic [9:0] DECAY_LAST = 10'(sarsa_pkg::DECAY_STEP - 1);

  // random value mod 3 by summing hex digits
  function automatic logic [1:0] mod3(input logic [30:0] v);
    logic [31:0] w;
    logic [6:0]  s;
    logic [13:0] t;
    logic [6:0]  q;
    logic [6:0]  rem;
    w = {1'b0, v};
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 7'(w[4*i +: 4]);
    end
    t = 14'(s) * 14'd43;
    q = t[13:7];
    rem = s - 7'(q * 7'd3);
    return rem[1:0];
  endfunction

  sarsa_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]  clr_r, clr_nxt;
  logic [AW-1:0]  cur_addr_r, cur_addr_nxt;
  logic           cur_q_nz_r, cur_q_nz_nxt;
  logic [31:0]    visit_r, visit_nxt;
  logic [22:0]    visit_k_r, visit_k_nxt;
  logic [9:0]     visit_m_r, visit_m_nxt;

  logic [15:0]    learn_r, learn_nxt;
  logic [15:0]    discount_r, discount_nxt;
  logic [15:0]    explore_div_r, explore_div_nxt;
  logic [31:0]    observe_r, observe_nxt;
  logic           frozen_r, frozen_nxt;
  logic           decay_r, decay_nxt;

  logic           kind_r, kind_nxt;
  logic [BWW-1:0] b_r, b_nxt;
  logic [QW-1:0]  q_r, q_nxt;
  logic [DW-1:0]  d_r, d_nxt;
  logic [1:0]     na_r, na_nxt;
  logic signed [31:0] reward_r, reward_nxt;
  logic [30:0]    rnd_r, rnd_nxt;
  logic           obs_r, obs_nxt;

  logic [AW-1:0]      nbase_r, nbase_nxt;
  logic signed [31:0] qc_r, qc_nxt;
  logic signed [33:0] inner_r, inner_nxt;
  logic signed [31:0] best_r, best_nxt;
  logic [1:0]         res_act_r, res_act_nxt;
  logic               res_exp_r, res_exp_nxt;

  logic                 out_valid_r, out_valid_nxt;
  sarsa_pkg::out_item_t out_data_r, out_data_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_rdata;

  logic signed [sarsa_pkg::MUL_A_W-1:0] mul_a;
  logic signed [sarsa_pkg::MUL_B_W-1:0] mul_b;
  logic signed [sarsa_pkg::PROD_W-1:0]  prod;

  logic [BWW-1:0] bw_upd_c, bw_cho_c;
  logic [27:0]    bw_prod_c;
  logic [QW-1:0]  q_clamp_c;
  logic [DW-1:0]  d_clamp_c;
  logic [AW-1:0]  row_c, cellrow_c, nbase_c;
  logic [22:0]    eps_c;
  logic           eps_nz_c;
  logic signed [31:0] t_c;
  logic signed [33:0] delta_c;
  logic signed [34:0] nv_c;
  logic signed [31:0] q_sat_c;

  sarsa_qmem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_qmem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  sarsa_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  // input clamps
  assign bw_prod_c = 28'(in_data.bandwidth[14:0]) * DIV100_K;
  assign bw_upd_c  = (in_data.bandwidth >= BW_DIV_LIMIT) ? BWW'(BW_BUCKETS - 1)
                                                         : bw_prod_c[sarsa_pkg::DIV100_SHIFT +: BWW];
  assign bw_cho_c  = (in_data.bandwidth >= 32'(BW_BUCKETS)) ? BWW'(BW_BUCKETS - 1)
                                                            : in_data.bandwidth[BWW-1:0];
  assign q_clamp_c = (in_data.queue_length >= 16'(QUEUE_BUCKETS)) ? QW'(QUEUE_BUCKETS - 1)
                                                                  : in_data.queue_length[QW-1:0];
  assign d_clamp_c = (in_data.drop_count >= 16'(DROP_BUCKETS)) ? DW'(DROP_BUCKETS - 1)
                                                               : in_data.drop_count[DW-1:0];

  // table address of the action-0 entry of the latched state
  assign row_c     = AW'(AW'(b_r) * QB_A) + AW'(q_r);
  assign cellrow_c = AW'(row_c * DB_A) + AW'(d_r);
  assign nbase_c   = AW'(cellrow_c * ACT_A);

  assign eps_c    = decay_r ? (visit_k_r + 23'd1) : 23'(explore_div_r);
  assign eps_nz_c = decay_r || (explore_div_r != 16'd0);

  assign t_c     = prod[47:16];
  assign delta_c = prod[49:16];
  assign nv_c    = {{3{qc_r[31]}}, qc_r} + {delta_c[33], delta_c};
  assign q_sat_c = (nv_c > Q_MAX) ? 32'sh7fffffff :
                   (nv_c < Q_MIN) ? 32'sh80000000 : nv_c[31:0];

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    cur_addr_nxt    = cur_addr_r;
    cur_q_nz_nxt    = cur_q_nz_r;
    visit_nxt       = visit_r;
    visit_k_nxt     = visit_k_r;
    visit_m_nxt     = visit_m_r;
    learn_nxt       = learn_r;
    discount_nxt    = discount_r;
    explore_div_nxt = explore_div_r;
    observe_nxt     = observe_r;
    frozen_nxt      = frozen_r;
    decay_nxt       = decay_r;
    kind_nxt        = kind_r;
    b_nxt           = b_r;
    q_nxt           = q_r;
    d_nxt           = d_r;
    na_nxt          = na_r;
    reward_nxt      = reward_r;
    rnd_nxt         = rnd_r;
    obs_nxt         = obs_r;
    nbase_nxt       = nbase_r;
    qc_nxt          = qc_r;
    inner_nxt       = inner_r;
    best_nxt        = best_r;
    res_act_nxt     = res_act_r;
    res_exp_nxt     = res_exp_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    mem_we          = 1'b0;
    mem_waddr       = cur_addr_r;
    mem_wdata       = q_sat_c;
    mem_raddr       = nbase_r;
    mul_a           = '0;
    mul_b           = '0;

    if (cfg_valid) begin
      case (cfg_index)
        sarsa_pkg::CFG_LEARN_RATE:  learn_nxt       = cfg_data[15:0];
        sarsa_pkg::CFG_DISCOUNT:    discount_nxt    = cfg_data[15:0];
        sarsa_pkg::CFG_EXPLORE_DIV: explore_div_nxt = cfg_data[15:0];
        sarsa_pkg::CFG_OBSERVE:     observe_nxt     = cfg_data;
        sarsa_pkg::CFG_FROZEN:      frozen_nxt      = cfg_data[0];
        sarsa_pkg::CFG_DECAY:       decay_nxt       = cfg_data[0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sarsa_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_A) begin
          state_nxt = sarsa_pkg::S_IDLE;
        end
      end
      sarsa_pkg::S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_data.kind;
          b_nxt      = (in_data.kind == sarsa_pkg::KIND_UPDATE) ? bw_upd_c : bw_cho_c;
          q_nxt      = q_clamp_c;
          d_nxt      = d_clamp_c;
          na_nxt     = (in_data.next_act == 2'd3) ? sarsa_pkg::ACT_DROP
                                                  : in_data.next_act;
          reward_nxt = in_data.reward;
          rnd_nxt    = in_data.random_value;
          obs_nxt    = (in_data.now <= observe_r);
          if (!(in_data.kind == sarsa_pkg::KIND_UPDATE && frozen_r)) begin
            state_nxt = sarsa_pkg::S_ADDR;
          end
        end
      end
      sarsa_pkg::S_ADDR: begin
        nbase_nxt = nbase_c;
        mem_raddr = cur_addr_r;
        if (kind_r == sarsa_pkg::KIND_UPDATE) begin
          state_nxt = sarsa_pkg::S_RDN;
        end else begin
          mul_a     = {5'b0, rnd_r};
          mul_b     = {1'b0, eps_c};
          state_nxt = sarsa_pkg::S_CRD0;
        end
      end
      sarsa_pkg::S_RDN: begin
        qc_nxt    = mem_rdata;
        mem_raddr = nbase_r + AW'(na_r);
        state_nxt = sarsa_pkg::S_MUL1;
      end
      sarsa_pkg::S_MUL1: begin
        mul_a     = {{4{mem_rdata[31]}}, mem_rdata};
        mul_b     = {8'b0, discount_r};
        state_nxt = sarsa_pkg::S_INNER;
      end
      sarsa_pkg::S_INNER: begin
        inner_nxt = {{2{reward_r[31]}}, reward_r} + {{2{t_c[31]}}, t_c}
                  - {{2{qc_r[31]}}, qc_r};
        state_nxt = sarsa_pkg::S_MUL2;
      end
      sarsa_pkg::S_MUL2: begin
        mul_a     = {{2{inner_r[33]}}, inner_r};
        mul_b     = {8'b0, learn_r};
        state_nxt = sarsa_pkg::S_WB;
      end
      sarsa_pkg::S_WB: begin
        mem_we       = 1'b1;
        mem_waddr    = cur_addr_r;
        mem_wdata    = q_sat_c;
        cur_addr_nxt = nbase_r + AW'(na_r);
        cur_q_nz_nxt = (q_r != '0);
        if (cur_q_nz_r && (visit_r != '1)) begin
          visit_nxt = visit_r + 32'd1;
          if (visit_m_r == DECAY_LAST) begin
            visit_m_nxt = '0;
            visit_k_nxt = visit_k_r + 23'd1;
          end else begin
            visit_m_nxt = visit_m_r + 10'd1;
          end
        end
        state_nxt = sarsa_pkg::S_IDLE;
      end
      sarsa_pkg::S_CRD0: begin
        mem_raddr = nbase_r + AW'(sarsa_pkg::ACT_PASS);
        if (obs_r) begin
          res_act_nxt = sarsa_pkg::ACT_PASS;
          res_exp_nxt = 1'b0;
          state_nxt   = sarsa_pkg::S_OUT;
        end else if (!frozen_r && eps_nz_c && (prod <= RAND_TOP)) begin
          res_act_nxt = mod3(rnd_r);
          res_exp_nxt = 1'b1;
          state_nxt   = sarsa_pkg::S_OUT;
        end else begin
          state_nxt = sarsa_pkg::S_CRD1;
        end
      end
      sarsa_pkg::S_CRD1: begin
        mem_raddr   = nbase_r + AW'(sarsa_pkg::ACT_ECN);
        best_nxt    = mem_rdata;
        res_act_nxt = sarsa_pkg::ACT_PASS;
        res_exp_nxt = 1'b0;
        state_nxt   = sarsa_pkg::S_CRD2;
      end
      sarsa_pkg::S_CRD2: begin
        mem_raddr = nbase_r + AW'(sarsa_pkg::ACT_DROP);
        if (mem_rdata > best_r) begin
          best_nxt    = mem_rdata;
          res_act_nxt = sarsa_pkg::ACT_ECN;
        end
        state_nxt = sarsa_pkg::S_CFIN;
      end
      sarsa_pkg::S_CFIN: begin
        if (mem_rdata > best_r) begin
          res_act_nxt = sarsa_pkg::ACT_DROP;
        end
        state_nxt = sarsa_pkg::S_OUT;
      end
      sarsa_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.action   = res_act_r;
          out_data_nxt.explored = res_exp_r;
          state_nxt             = sarsa_pkg::S_IDLE;
        end
      end
      default: state_nxt = sarsa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sarsa_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r         <= '0;
      cur_addr_r    <= '0;
      cur_q_nz_r    <= 1'b0;
      visit_r       <= '0;
      visit_k_r     <= '0;
      visit_m_r     <= '0;
      learn_r       <= sarsa_pkg::LEARN_RATE_RST;
      discount_r    <= sarsa_pkg::DISCOUNT_RST;
      explore_div_r <= '0;
      observe_r     <= '0;
      frozen_r      <= 1'b0;
      decay_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      clr_r         <= clr_nxt;
      cur_addr_r    <= cur_addr_nxt;
      cur_q_nz_r    <= cur_q_nz_nxt;
      visit_r       <= visit_nxt;
      visit_k_r     <= visit_k_nxt;
      visit_m_r     <= visit_m_nxt;
      learn_r       <= learn_nxt;
      discount_r    <= discount_nxt;
      explore_div_r <= explore_div_nxt;
      observe_r     <= observe_nxt;
      frozen_r      <= frozen_nxt;
      decay_r       <= decay_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // item payload, no reset
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    b_r        <= b_nxt;
    q_r        <= q_nxt;
    d_r        <= d_nxt;
    na_r       <= na_nxt;
    reward_r   <= reward_nxt;
    rnd_r      <= rnd_nxt;
    obs_r      <= obs_nxt;
    nbase_r    <= nbase_nxt;
    qc_r       <= qc_nxt;
    inner_r    <= inner_nxt;
    best_r     <= best_nxt;
    res_act_r  <= res_act_nxt;
    res_exp_r  <= res_exp_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != sarsa_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SARSA_ASSERT_NEXT(a_frozen_update_no_move,
    in_valid && !in_stall && (in_data.kind == sarsa_pkg::KIND_UPDATE) && frozen_r,
    (state_r == sarsa_pkg::S_IDLE) && $stable(cur_addr_r) && $stable(visit_r),
    "frozen update changed agent state")
  `SARSA_ASSERT_NOW(a_write_phase,
    mem_we,
    (state_r == sarsa_pkg::S_CLEAR) || (state_r == sarsa_pkg::S_WB),
    "table written outside clear or write-back")
  `SARSA_ASSERT_NEXT(a_visit_monotonic,
    1'b1,
    (visit_r >= $past(visit_r)) && (visit_m_r < 10'(sarsa_pkg::DECAY_STEP)),
    "visit count went backwards or remainder overflowed")

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench of the tabular sarsa queue-management agent
`timescale 1ns / 1ps

module tb_top;

  localparam int TBL_DEPTH = sarsa_pkg::BW_BUCKETS_DEF * sarsa_pkg::QUEUE_BUCKETS_DEF
                             * sarsa_pkg::DROP_BUCKETS_DEF * sarsa_pkg::NUM_ACTIONS;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_SHOWN = 10;
  localparam logic [15:0] EXPLORE_OFF = 16'd0;
  localparam logic [31:0] OBSERVE_OFF = 32'd0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sarsa_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sarsa_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sarsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predicted agent state and settings
  logic signed [31:0] q_mem [TBL_DEPTH];
  logic [3:0] cur_bw;
  logic [4:0] cur_queue;
  logic [2:0] cur_drop;
  logic [1:0] cur_act;
  logic [31:0] visits;
  logic [15:0] alpha;
  logic [15:0] gamma;
  logic [15:0] eps_div;
  logic [31:0] observe_end;
  logic frozen;
  logic decay;

  sarsa_pkg::out_item_t expected_choices [$];
  int mismatches = 0;
  bit calm = 1'b0;

  sarsa_aqm_agent i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [3:0] clamp_bw(input logic [31:0] v);
    return (v >= sarsa_pkg::BW_BUCKETS_DEF) ? 4'(sarsa_pkg::BW_BUCKETS_DEF - 1) : v[3:0];
  endfunction

  function automatic logic [4:0] clamp_queue(input logic [15:0] v);
    return (v >= sarsa_pkg::QUEUE_BUCKETS_DEF) ? 5'(sarsa_pkg::QUEUE_BUCKETS_DEF - 1)
                                               : v[4:0];
  endfunction

  function automatic logic [2:0] clamp_drop(input logic [15:0] v);
    return (v >= sarsa_pkg::DROP_BUCKETS_DEF) ? 3'(sarsa_pkg::DROP_BUCKETS_DEF - 1) : v[2:0];
  endfunction

  function automatic int slot_of(input logic [3:0] b, input logic [4:0] q,
                                 input logic [2:0] d, input logic [1:0] a);
    return ((int'(b) * sarsa_pkg::QUEUE_BUCKETS_DEF + int'(q)) * sarsa_pkg::DROP_BUCKETS_DEF
            + int'(d)) * sarsa_pkg::NUM_ACTIONS + int'(a);
  endfunction

  function automatic sarsa_pkg::in_item_t make_update(input logic [31:0] bw,
                                                      input logic [15:0] ql,
                                                      input logic [15:0] dr,
                                                      input logic [1:0] na,
                                                      input logic [31:0] rew);
    sarsa_pkg::in_item_t it;
    it.kind = sarsa_pkg::KIND_UPDATE;
    it.bandwidth = bw;
    it.queue_length = ql;
    it.drop_count = dr;
    it.next_act = na;
    it.reward = rew;
    it.random_value = 31'($urandom);
    it.now = $urandom;
    return it;
  endfunction

  function automatic sarsa_pkg::in_item_t make_choose(input logic [31:0] bw,
                                                      input logic [15:0] ql,
                                                      input logic [15:0] dr,
                                                      input logic [30:0] rnd,
                                                      input logic [31:0] now_v);
    sarsa_pkg::in_item_t it;
    it.kind = sarsa_pkg::KIND_CHOOSE;
    it.bandwidth = bw;
    it.queue_length = ql;
    it.drop_count = dr;
    it.next_act = 2'($urandom);
    it.reward = $urandom;
    it.random_value = rnd;
    it.now = now_v;
    return it;
  endfunction

  function automatic sarsa_pkg::in_item_t make_noise();
    sarsa_pkg::in_item_t it;
    it.kind = 1'($urandom);
    it.bandwidth = $urandom;
    it.queue_length = 16'($urandom);
    it.drop_count = 16'($urandom);
    it.next_act = 2'($urandom);
    it.reward = $urandom;
    it.random_value = 31'($urandom);
    it.now = $urandom;
    return it;
  endfunction

  task automatic reset_model();
    for (int i = 0; i < TBL_DEPTH; i++) q_mem[i] = '0;
    cur_bw = '0;
    cur_queue = '0;
    cur_drop = '0;
    cur_act = sarsa_pkg::ACT_PASS;
    visits = '0;
    alpha = sarsa_pkg::LEARN_RATE_RST;
    gamma = sarsa_pkg::DISCOUNT_RST;
    eps_div = EXPLORE_OFF;
    observe_end = OBSERVE_OFF;
    frozen = 1'b0;
    decay = 1'b0;
  endtask

  task automatic predict_decision(input sarsa_pkg::in_item_t it);
    logic [3:0] nb;
    logic [4:0] nq;
    logic [2:0] nd;
    logic [1:0] na;
    int ci;
    int ni;
    longint qc;
    longint qn;
    longint inner;
    longint delta;
    longint nv;
    longint unsigned eps;
    longint unsigned rnd;
    logic signed [31:0] qp;
    logic signed [31:0] qe;
    logic signed [31:0] qd;
    sarsa_pkg::out_item_t res;
    nq = clamp_queue(it.queue_length);
    nd = clamp_drop(it.drop_count);
    if (it.kind == sarsa_pkg::KIND_UPDATE) begin
      if (frozen) return;
      na = (it.next_act > sarsa_pkg::ACT_DROP) ? sarsa_pkg::ACT_DROP : it.next_act;
      nb = clamp_bw(it.bandwidth / sarsa_pkg::BW_QUANTUM);
      if (cur_queue != 0 && visits != 32'hFFFF_FFFF) visits = visits + 1;
      ci = slot_of(cur_bw, cur_queue, cur_drop, cur_act);
      ni = slot_of(nb, nq, nd, na);
      qc = longint'(q_mem[ci]);
      qn = longint'(q_mem[ni]);
      inner = longint'($signed(it.reward)) + ((longint'(gamma) * qn) >>> 16) - qc;
      delta = (longint'(alpha) * inner) >>> 16;
      nv = qc + delta;
      if (nv > 64'sh7FFF_FFFF) nv = 64'sh7FFF_FFFF;
      if (nv < -64'sh8000_0000) nv = -64'sh8000_0000;
      q_mem[ci] = nv[31:0];
      cur_bw = nb;
      cur_queue = nq;
      cur_drop = nd;
      cur_act = na;
    end else begin
      res.action = sarsa_pkg::ACT_PASS;
      res.explored = 1'b0;
      rnd = longint'(it.random_value);
      eps = decay ? (64'd1 + 64'(visits / sarsa_pkg::DECAY_STEP)) : 64'(eps_div);
      nb = clamp_bw(it.bandwidth);
      if (it.now <= observe_end) begin
        res.action = sarsa_pkg::ACT_PASS;
      end else if (!frozen && eps != 0 && rnd * eps <= 64'h7FFF_FFFF) begin
        res.action = 2'(rnd % sarsa_pkg::NUM_ACTIONS);
        res.explored = 1'b1;
      end else begin
        qp = q_mem[slot_of(nb, nq, nd, sarsa_pkg::ACT_PASS)];
        qe = q_mem[slot_of(nb, nq, nd, sarsa_pkg::ACT_ECN)];
        qd = q_mem[slot_of(nb, nq, nd, sarsa_pkg::ACT_DROP)];
        if (qp >= qe && qp >= qd) res.action = sarsa_pkg::ACT_PASS;
        else if (qe >= qd) res.action = sarsa_pkg::ACT_ECN;
        else res.action = sarsa_pkg::ACT_DROP;
      end
      expected_choices.push_back(res);
    end
  endtask

  task automatic write_reg(input logic [sarsa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sarsa_pkg::CFG_LEARN_RATE:  alpha = val[15:0];
      sarsa_pkg::CFG_DISCOUNT:    gamma = val[15:0];
      sarsa_pkg::CFG_EXPLORE_DIV: eps_div = val[15:0];
      sarsa_pkg::CFG_OBSERVE:     observe_end = val;
      sarsa_pkg::CFG_FROZEN:      frozen = val[0];
      sarsa_pkg::CFG_DECAY:       decay = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input sarsa_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_decision(it);
    if (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // hold the sender until every decision is back and the pipeline has drained
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_choices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] a, input logic [15:0] g,
                                input logic [15:0] e, input logic [31:0] obs,
                                input logic fr, input logic dc);
    settle();
    write_reg(sarsa_pkg::CFG_LEARN_RATE, 32'(a));
    write_reg(sarsa_pkg::CFG_DISCOUNT, 32'(g));
    write_reg(sarsa_pkg::CFG_EXPLORE_DIV, 32'(e));
    write_reg(sarsa_pkg::CFG_OBSERVE, obs);
    write_reg(sarsa_pkg::CFG_FROZEN, 32'(fr));
    write_reg(sarsa_pkg::CFG_DECAY, 32'(dc));
  endtask

  task automatic test_reset_state();
    send_item(make_choose(32'd0, 16'd0, 16'd0, 31'd0, 32'd0));
    send_item(make_choose(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_tie_order();
    apply_settings(16'hFFFF, 16'd0, EXPLORE_OFF, OBSERVE_OFF, 1'b0, 1'b0);
    send_item(make_update(32'd0, 16'd0, 16'd0, sarsa_pkg::ACT_ECN, 32'hFFFF_0000));
    send_item(make_choose(32'd0, 16'd0, 16'd0, 31'd5, 32'd1));
    send_item(make_update(32'd99, 16'd0, 16'd0, sarsa_pkg::ACT_DROP, 32'h0001_0000));
    send_item(make_choose(32'd0, 16'd0, 16'd0, 31'd5, 32'd1));
    send_item(make_update(32'd0, 16'd0, 16'd0, sarsa_pkg::ACT_PASS, 32'h4000_0000));
    send_item(make_choose(32'd0, 16'd0, 16'd0, 31'd5, 32'd1));
  endtask

  task automatic test_saturation();
    apply_settings(16'hFFFF, 16'hFFFF, EXPLORE_OFF, OBSERVE_OFF, 1'b0, 1'b0);
    repeat (3) send_item(make_update(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, ACT_SPARE,
                                     32'h7FFF_FFFF));
    send_item(make_choose(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 31'd9, 32'd2));
    repeat (3) send_item(make_update(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, ACT_SPARE,
                                     32'h8000_0000));
    send_item(make_choose(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 31'd9, 32'd2));
    // choose takes the bandwidth undivided
    send_item(make_choose(32'd1500, 16'd31, 16'd7, 31'd9, 32'd2));
  endtask

  task automatic test_frozen_mode();
    apply_settings(sarsa_pkg::LEARN_RATE_RST, sarsa_pkg::DISCOUNT_RST, 16'd1, OBSERVE_OFF,
                   1'b1, 1'b0);
    send_item(make_update(32'd700, 16'd12, 16'd3, sarsa_pkg::ACT_ECN, 32'h0100_0000));
    send_item(make_choose(32'd7, 16'd12, 16'd3, 31'd0, 32'd3));
  endtask

  task automatic test_exploration();
    apply_settings(sarsa_pkg::LEARN_RATE_RST, sarsa_pkg::DISCOUNT_RST, 16'd1, OBSERVE_OFF,
                   1'b0, 1'b0);
    send_item(make_choose(32'd3, 16'd4, 16'd1, 31'h7FFF_FFFF, 32'd10));
    apply_settings(sarsa_pkg::LEARN_RATE_RST, sarsa_pkg::DISCOUNT_RST, 16'hFFFF, OBSERVE_OFF,
                   1'b0, 1'b0);
    send_item(make_choose(32'd3, 16'd4, 16'd1, 31'd0, 32'd10));
    send_item(make_choose(32'd3, 16'd4, 16'd1, 31'd32768, 32'd10));
    send_item(make_choose(32'd3, 16'd4, 16'd1, 31'd32769, 32'd10));
    apply_settings(sarsa_pkg::LEARN_RATE_RST, sarsa_pkg::DISCOUNT_RST, EXPLORE_OFF,
                   OBSERVE_OFF, 1'b0, 1'b1);
    send_item(make_choose(32'd3, 16'd4, 16'd1, 31'($urandom), 32'd10));
  endtask

  task automatic test_observation();
    apply_settings(sarsa_pkg::LEARN_RATE_RST, sarsa_pkg::DISCOUNT_RST, 16'd2, 32'hFFFF_FFFF,
                   1'b0, 1'b0);
    send_item(make_choose(32'd0, 16'd0, 16'd0, 31'd0, 32'hFFFF_FFFF));
    apply_settings(sarsa_pkg::LEARN_RATE_RST, sarsa_pkg::DISCOUNT_RST, 16'd2, 32'd1000,
                   1'b0, 1'b0);
    send_item(make_choose(32'd0, 16'd0, 16'd0, 31'd0, 32'd1000));
    send_item(make_choose(32'd0, 16'd0, 16'd0, 31'd0, 32'd1001));
  endtask

  // update followed by a choose on the new state, mixed with raw noise items
  task automatic run_learning(input int count);
    int sent;
    logic [31:0] b;
    logic [31:0] bw;
    logic [15:0] ql;
    logic [15:0] dr;
    logic [31:0] rew;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        send_item(make_noise());
        sent++;
      end else begin
        b = 32'($urandom_range(0, 3));
        bw = ($urandom_range(19) == 0) ? $urandom
                                       : b * sarsa_pkg::BW_QUANTUM
                                         + 32'($urandom_range(0, 99));
        ql = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        dr = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        rew = ($urandom_range(9) == 0) ? $urandom
                                       : 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
        send_item(make_update(bw, ql, dr, 2'($urandom_range(0, 3)), rew));
        send_item(make_choose(b, ql, dr, 31'($urandom), $urandom));
        sent += 2;
      end
    end
  endtask

  task automatic test_random_learning();
    apply_settings(sarsa_pkg::LEARN_RATE_RST, sarsa_pkg::DISCOUNT_RST, EXPLORE_OFF,
                   OBSERVE_OFF, 1'b0, 1'b0);
    run_learning(320);
    apply_settings(16'hFFFF, 16'd0, 16'd16, 32'h8000_0000, 1'b0, 1'b0);
    run_learning(320);
    calm = 1'b1;
    apply_settings(16'd32768, 16'hFFFF, 16'hFFFF, OBSERVE_OFF, 1'b0, 1'b1);
    run_learning(350);
    calm = 1'b0;
    apply_settings(16'd20000, 16'd40000, 16'd2, OBSERVE_OFF, 1'b1, 1'b0);
    run_learning(150);
    apply_settings(16'd1000, 16'd30000, 16'd4, OBSERVE_OFF, 1'b0, 1'b0);
    run_learning(200);
    settle();
    run_learning(200);
    apply_settings(16'd0, 16'hFFFF, 16'd3, 32'd1000, 1'b0, 1'b0);
    run_learning(300);
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 22);
  end

  always @(posedge clk) begin
    sarsa_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_choices.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected decision: action %0d explored %0d", out_data.action,
                   out_data.explored);
      end else begin
        want = expected_choices.pop_front();
        if (out_data.action !== want.action || out_data.explored !== want.explored) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch: expected action %0d explored %0d, got action %0d explored %0d",
                     want.action, want.explored, out_data.action, out_data.explored);
        end
      end
    end
  end

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_tie_order();
    test_saturation();
    test_frozen_mode();
    test_exploration();
    test_observation();
    test_random_learning();
    settle();
    if (mismatches == 0 && expected_choices.size() == 0) begin
      $display("sarsa_aqm_agent verification clean");
    end else begin
      $display("sarsa_aqm_agent verification failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("sarsa_aqm_agent verification failed");
    $finish;
  end

endmodule

// ===== sarsa_aqm_agent.f =====
+incdir+design
design/sarsa_pkg.sv
design/sarsa_qmem.sv
design/sarsa_mul.sv
design/sarsa_aqm_agent.sv
verif/tb_top.sv
